FILE: sv/gnsm_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and codes of the greedy nearest star matcher
// no dependencies; imported by every module of the block
package gnsm_pkg;

	localparam int MAX_REF    = 256;
	localparam int IDX_W      = $clog2(MAX_REF);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_W    = 24;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int D2_W       = SQ_W + 1;
	localparam int RADIUS_W   = 16;
	localparam int R2_W       = 2 * RADIUS_W;
	localparam int ACTION_W   = 2;
	localparam int STATUS_W   = 2;
	localparam int OUT_IDX_W  = 8;
	// command queue depth, a power of two
	localparam int Q_DEPTH    = 2;
	localparam int QP_W       = $clog2(Q_DEPTH);

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd7680;

	// input action codes
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_MATCH = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

	// internal operation codes after decode
	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_MATCH,
		OP_NOP
	} op_t;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MATCHED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_IDX_W-1:0] ref_index;
		logic [COORD_W-1:0]   ref_x;
		logic [COORD_W-1:0]   ref_y;
		logic [OUT_IDX_W-1:0] pair_index;
	} res_t;

endpackage

FILE: sv/gnsm_front.sv
`timescale 1ns / 1ps
// front end: accepts input transactions, decodes the action and queues commands
// depends on gnsm_pkg
module gnsm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [gnsm_pkg::ACTION_W-1:0] in_action,
	input  logic [gnsm_pkg::COORD_W-1:0]  in_pos_x,
	input  logic [gnsm_pkg::COORD_W-1:0]  in_pos_y,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output gnsm_pkg::cmd_t cmd
);
	import gnsm_pkg::*;

	cmd_t            queue_q [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0]   cnt_q;
	cmd_t            dec;
	logic            push;
	logic            pop;

	always_comb begin
		dec.pos_x = in_pos_x;
		dec.pos_y = in_pos_y;
		unique case (in_action)
			ACT_CLEAR: dec.op = OP_CLEAR;
			ACT_LOAD:  dec.op = OP_LOAD;
			ACT_MATCH: dec.op = OP_MATCH;
			ACT_NONE:  dec.op = OP_NOP;
			default:   dec.op = OP_NOP;
		endcase
	end

	assign in_ready  = (cnt_q != (QP_W + 1)'(Q_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QP_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QP_W + 1)'(1);
			end
		end
	end

endmodule

FILE: sv/gnsm_back.sv
`timescale 1ns / 1ps
// back end: star store, used marks, nearest-star scan pipeline and result register
// depends on gnsm_pkg
module gnsm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [gnsm_pkg::RADIUS_W-1:0] cfg_data,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  gnsm_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output gnsm_pkg::res_t res
);
	import gnsm_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]          state_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [R2_W-1:0]     r2_q;
	logic [CNT_W-1:0]    ref_count_q;
	logic [CNT_W-1:0]    pair_count_q;
	logic                used_q  [MAX_REF];
	logic [COORD_W-1:0]  ref_x_q [MAX_REF];
	logic [COORD_W-1:0]  ref_y_q [MAX_REF];
	logic [IDX_W-1:0]    scan_idx_q;
	logic [COORD_W-1:0]  px_q;
	logic [COORD_W-1:0]  py_q;

	// scan pipeline
	logic                vld_s1, vld_s2, vld_s3;
	logic                used_s1, used_s2, used_s3;
	logic [IDX_W-1:0]    idx_s1, idx_s2, idx_s3;
	logic [COORD_W-1:0]  x_s1, x_s2, x_s3;
	logic [COORD_W-1:0]  y_s1, y_s2, y_s3;
	logic [COORD_W-1:0]  dx_s2, dy_s2;
	logic [SQ_W-1:0]     sqx_s3, sqy_s3;

	// best candidate so far
	logic                found_q;
	logic [D2_W-1:0]     best_d2_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [COORD_W-1:0]  best_x_q;
	logic [COORD_W-1:0]  best_y_q;

	res_t                res_q;
	logic                res_valid_q;

	logic                out_free;
	logic                take;
	logic                full;
	logic                last_issue;
	logic                pipe_empty;
	logic                finish;
	logic                hit;
	logic [D2_W-1:0]     d2;
	logic                better;
	logic [IDX_W-1:0]    load_idx;

	assign out_free   = !res_valid_q || res_ready;
	assign cmd_ready  = (state_q == S_IDLE) && out_free;
	assign take       = cmd_valid && cmd_ready;
	assign full       = (ref_count_q == CNT_W'(MAX_REF));
	assign load_idx   = ref_count_q[IDX_W-1:0];
	assign last_issue = (CNT_W'(scan_idx_q) == ref_count_q - CNT_W'(1));
	assign pipe_empty = !vld_s1 && !vld_s2 && !vld_s3;
	assign finish     = (state_q == S_DRAIN) && pipe_empty && out_free;
	assign hit        = found_q && (best_d2_q <= D2_W'(r2_q));
	assign d2         = D2_W'(sqx_s3) + D2_W'(sqy_s3);
	assign better     = vld_s3 && !used_s3 && (!found_q || d2 < best_d2_q);

	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// star store and used marks: one write port, one registered read port for the scan
	// marks need no bulk clear, every entry below the count got its mark cleared on load
	always_ff @(posedge clk) begin
		if (take && cmd.op == OP_LOAD && !full) begin
			ref_x_q[load_idx] <= cmd.pos_x;
			ref_y_q[load_idx] <= cmd.pos_y;
			used_q[load_idx]  <= 1'b0;
		end else if (finish && hit) begin
			used_q[best_idx_q] <= 1'b1;
		end
		x_s1    <= ref_x_q[scan_idx_q];
		y_s1    <= ref_y_q[scan_idx_q];
		used_s1 <= used_q[scan_idx_q];
	end

	// payload stages of the distance pipeline
	always_ff @(posedge clk) begin
		idx_s1  <= scan_idx_q;
		idx_s2  <= idx_s1;
		used_s2 <= used_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		dx_s2   <= (px_q >= x_s1) ? (px_q - x_s1) : (x_s1 - px_q);
		dy_s2   <= (py_q >= y_s1) ? (py_q - y_s1) : (y_s1 - py_q);
		idx_s3  <= idx_s2;
		used_s3 <= used_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		sqx_s3  <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3  <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		if (take && cmd.op == OP_MATCH) begin
			px_q <= cmd.pos_x;
			py_q <= cmd.pos_y;
			r2_q <= R2_W'(radius_q) * R2_W'(radius_q);
		end
		if (better) begin
			best_d2_q  <= d2;
			best_idx_q <= idx_s3;
			best_x_q   <= x_s3;
			best_y_q   <= y_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			radius_q     <= RADIUS_RESET;
			ref_count_q  <= '0;
			pair_count_q <= '0;
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radius_q <= cfg_data;
			end
			vld_s1 <= (state_q == S_SCAN);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (better) begin
				found_q <= 1'b1;
			end
			if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (cmd.op == OP_MATCH) begin
							found_q    <= 1'b0;
							scan_idx_q <= '0;
							// empty store: nothing to scan
							state_q    <= (ref_count_q == '0) ? S_DRAIN : S_SCAN;
						end else begin
							res_valid_q <= 1'b1;
						end
						if (cmd.op == OP_CLEAR) begin
							ref_count_q  <= '0;
							pair_count_q <= '0;
						end
						if (cmd.op == OP_LOAD && !full) begin
							ref_count_q <= ref_count_q + CNT_W'(1);
						end
					end
				end
				S_SCAN: begin
					if (last_issue) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (finish) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (hit) begin
							pair_count_q <= pair_count_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (take && cmd.op != OP_MATCH) begin
			res_q <= '0;
			if (cmd.op == OP_LOAD) begin
				if (full) begin
					res_q.status <= ST_FULL;
				end else begin
					res_q.status    <= ST_DONE;
					res_q.ref_index <= OUT_IDX_W'(load_idx);
					res_q.ref_x     <= cmd.pos_x;
					res_q.ref_y     <= cmd.pos_y;
				end
			end else begin
				res_q.status <= ST_DONE;
			end
		end else if (finish) begin
			res_q <= '0;
			if (hit) begin
				res_q.status     <= ST_MATCHED;
				res_q.ref_index  <= OUT_IDX_W'(best_idx_q);
				res_q.ref_x      <= best_x_q;
				res_q.ref_y      <= best_y_q;
				res_q.pair_index <= OUT_IDX_W'(pair_count_q);
			end else begin
				res_q.status <= ST_NOMATCH;
			end
		end
	end

endmodule

FILE: sv/greedy_nearest_star_matcher.sv
`timescale 1ns / 1ps
// clear, load and misc actions: the command passes the queue, then the result register
// match: the queue, a pipelined scan of the stored stars (none with an empty store), then the
// result register; one star read per cycle; the back end takes no new command during a scan,
// but a two-entry command queue lets new transactions in while a scan runs
// arst_n clears the queue, star and pair counts; a load clears its used mark; radius 30.0 px
// top level of the greedy nearest star matcher; depends on gnsm_pkg, gnsm_front, gnsm_back
module greedy_nearest_star_matcher (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // pos_x [23:0], pos_y [47:24]
	input  logic [gnsm_pkg::ACTION_W-1:0] s_axis_tuser,   // action [1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // ref_index [7:0], ref_x [31:8], ref_y [55:32],
	                                    // pair_index [63:56]
	output logic [gnsm_pkg::STATUS_W-1:0] m_axis_tuser,   // status [1:0]
	// match radius register, Q8.8 pixels
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [gnsm_pkg::RADIUS_W-1:0] cfg_data
);
	import gnsm_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	res_t res;

	// the user must write the radius only while idle; the block does not enforce it, writes are always taken
	assign cfg_ready = 1'b1;

	// front: decode each transaction and queue it
	gnsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_pos_x  (s_axis_tdata[COORD_W-1:0]),
		.in_pos_y  (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// back: store, used marks, distance scan and result register
	gnsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// pack the result fields lowest first
	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {res.pair_index, res.ref_y, res.ref_x, res.ref_index};

endmodule

FILE: sv/gnsm_checker.sv
`timescale 1ns / 1ps
// port-level checks of the greedy nearest star matcher and its bind
// depends on gnsm_pkg and greedy_nearest_star_matcher
module gnsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [gnsm_pkg::STATUS_W-1:0] m_axis_tuser
);
	import gnsm_pkg::*;

	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// transactions taken in but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped before transaction");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 3'd0)
		else $error("result without a pending input transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many transactions in flight");

	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_NOMATCH || m_axis_tuser == ST_FULL)
		|-> m_axis_tdata == 64'd0)
		else $error("no-match or full result carries data");

endmodule

bind greedy_nearest_star_matcher gnsm_checker u_gnsm_checker (.*);

FILE: tb/greedy_nearest_star_matcher_test.sv
`timescale 1ns / 1ps
// regression bench for the greedy nearest star matcher: directed table, then random star scenes
// depends on gnsm_pkg and greedy_nearest_star_matcher; carries its own behavioral copy of the matcher
module greedy_nearest_star_matcher_test;
	import gnsm_pkg::*;

	localparam int ITEM_TARGET = 1850;
	localparam int HOLD_CYCLES = 400;
	localparam logic [COORD_W-1:0] MID  = 24'h100000;
	localparam logic [COORD_W-1:0] MAXC = 24'hFFFFFF;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;              // pos_x [23:0], pos_y [47:24]
	logic [ACTION_W-1:0] s_axis_tuser;      // action [1:0]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;              // ref_index, ref_x, ref_y, pair_index
	logic [STATUS_W-1:0] m_axis_tuser;      // status [1:0]
	logic cfg_valid;
	logic cfg_ready;
	logic [RADIUS_W-1:0] cfg_data;

	greedy_nearest_star_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// bench copy of the star store and matcher state
	logic [COORD_W-1:0] star_x [MAX_REF];
	logic [COORD_W-1:0] star_y [MAX_REF];
	bit star_used [MAX_REF];
	int star_count;
	int pair_count;
	logic [RADIUS_W-1:0] radius_q;

	res_t owed_results[$];
	int mismatches;
	int items_sent;
	int feed_calm;
	int sink_calm;
	bit hold_armed;

	typedef struct {
		logic [ACTION_W-1:0]  act;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		bit                   typed;
		logic [STATUS_W-1:0]  st;
		logic [OUT_IDX_W-1:0] idx;
		logic [COORD_W-1:0]   rx;
		logic [COORD_W-1:0]   ry;
		logic [OUT_IDX_W-1:0] pr;
	} probe_row_t;

	// radius stays at its reset value (30 px) for the whole table
	probe_row_t directed_rows [23] = '{
		// empty store, then an action code that does nothing
		'{ACT_MATCH, 0, 0, 1, ST_NOMATCH, 0, 0, 0, 0},
		'{ACT_NONE, MAXC, MAXC, 1, ST_DONE, 0, 0, 0, 0},
		// stars at both corners of the coordinate range
		'{ACT_LOAD, 0, 0, 1, ST_DONE, 0, 0, 0, 0},
		'{ACT_LOAD, MAXC, MAXC, 1, ST_DONE, 1, MAXC, MAXC, 0},
		// exactly on the radius, source below the star
		'{ACT_MATCH, MAXC, MAXC - 24'd7680, 1, ST_MATCHED, 1, MAXC, MAXC, 0},
		// nearest star already used, the other far away
		'{ACT_MATCH, MAXC, MAXC, 1, ST_NOMATCH, 0, 0, 0, 0},
		// one step beyond the radius, then exactly on it
		'{ACT_MATCH, 24'd7681, 0, 1, ST_NOMATCH, 0, 0, 0, 0},
		'{ACT_MATCH, 24'd7680, 0, 1, ST_MATCHED, 0, 0, 0, 1},
		'{ACT_CLEAR, MAXC, 0, 1, ST_DONE, 0, 0, 0, 0},
		'{ACT_MATCH, 0, 0, 1, ST_NOMATCH, 0, 0, 0, 0},
		// three stars at equal distance, lowest index has to win
		'{ACT_LOAD, MID + 24'd100, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_LOAD, MID - 24'd100, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_LOAD, MID, MID + 24'd100, 0, 0, 0, 0, 0, 0},
		'{ACT_MATCH, MID, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_MATCH, MID, MID, 0, 0, 0, 0, 0, 0},
		// duplicate positions at distance zero beat the leftover
		'{ACT_LOAD, MID, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_LOAD, MID, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_MATCH, MID, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_MATCH, MID, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_MATCH, MID, MID, 0, 0, 0, 0, 0, 0},
		// everything used
		'{ACT_MATCH, MID, MID, 0, 0, 0, 0, 0, 0},
		'{ACT_NONE, 0, 0, 1, ST_DONE, 0, 0, 0, 0},
		'{ACT_CLEAR, 0, MAXC, 1, ST_DONE, 0, 0, 0, 0}
	};

	// what the matcher returns for one input transaction; updates the bench state
	function automatic res_t matcher_outcome(logic [ACTION_W-1:0] act,
			logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
		res_t r;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [D2_W-1:0] d2;
		logic [D2_W-1:0] best_d2;
		logic [R2_W-1:0] r2;
		int best;
		int i;
		r = '0;
		best_d2 = '0;
		case (act)
			ACT_CLEAR: begin
				for (i = 0; i < MAX_REF; i++)
					star_used[i] = 1'b0;
				star_count = 0;
				pair_count = 0;
			end
			ACT_LOAD: begin
				if (star_count >= MAX_REF) begin
					r.status = ST_FULL;
				end else begin
					star_x[star_count] = px;
					star_y[star_count] = py;
					star_used[star_count] = 1'b0;
					r.status = ST_DONE;
					r.ref_index = OUT_IDX_W'(star_count);
					r.ref_x = px;
					r.ref_y = py;
					star_count++;
				end
			end
			ACT_MATCH: begin
				r2 = radius_q * radius_q;
				best = -1;
				for (i = 0; i < star_count; i++) begin
					if (!star_used[i]) begin
						dx = (px >= star_x[i]) ? px - star_x[i] : star_x[i] - px;
						dy = (py >= star_y[i]) ? py - star_y[i] : star_y[i] - py;
						d2 = dx * dx + dy * dy;
						// strict less keeps the lowest index on a tie
						if (best < 0 || d2 < best_d2) begin
							best = i;
							best_d2 = d2;
						end
					end
				end
				if (best >= 0 && best_d2 <= D2_W'(r2)) begin
					star_used[best] = 1'b1;
					r.status = ST_MATCHED;
					r.ref_index = OUT_IDX_W'(best);
					r.ref_x = star_x[best];
					r.ref_y = star_y[best];
					r.pair_index = OUT_IDX_W'(pair_count);
					pair_count++;
				end else begin
					r.status = ST_NOMATCH;
				end
			end
			default: r.status = ST_DONE;
		endcase
		return r;
	endfunction

	// mostly no gap or a short one, now and then a long one or a calm stretch
	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(MAXC))
			return MAXC;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base, int span);
		return clamp_coord(longint'(base) + longint'($urandom_range(0, 2 * span)) - span);
	endfunction

	// corners of the range show up often enough to hit the clamping edges
	function automatic logic [COORD_W-1:0] rand_coord();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return MAXC;
		return COORD_W'($urandom);
	endfunction

	task automatic send_item(logic [ACTION_W-1:0] act, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py);
		int gap;
		@(negedge clk);
		gap = pick_gap(feed_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {py, px};
		do @(posedge clk); while (!s_axis_tready);
		owed_results.push_back(matcher_outcome(act, px, py));
		items_sent++;
	endtask

	// stop offering and wait until every owed result has come back
	task automatic drain(int settle);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_W-1:0] value);
		drain(8);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		radius_q = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one field of a star, a load burst around it, then source stars mostly
	// placed near the loaded ones so that the radius test decides the outcome
	task automatic run_scene(bit fresh, int loads, int probes);
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COORD_W-1:0] lx[$];
		logic [COORD_W-1:0] ly[$];
		int spread;
		int jitter;
		int roll;
		int k;
		int n;
		if (fresh)
			send_item(ACT_CLEAR, rand_coord(), rand_coord());
		cx = rand_coord();
		cy = rand_coord();
		spread = 2 * int'(radius_q) + 16;
		jitter = int'(radius_q) + int'(radius_q) / 4 + 2;
		for (n = 0; n < loads; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 10 && lx.size() > 0) begin
				// duplicate of an earlier star
				k = $urandom_range(0, lx.size() - 1);
				px = lx[k];
				py = ly[k];
			end else if (roll < 20 && lx.size() > 0) begin
				// mirror image around the center, a tie for a source there
				k = $urandom_range(0, lx.size() - 1);
				px = clamp_coord(2 * longint'(cx) - longint'(lx[k]));
				py = clamp_coord(2 * longint'(cy) - longint'(ly[k]));
			end else begin
				px = nudge(cx, spread);
				py = nudge(cy, spread);
			end
			send_item(ACT_LOAD, px, py);
			lx.push_back(px);
			ly.push_back(py);
		end
		for (n = 0; n < probes; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				send_item(ACT_NONE, rand_coord(), rand_coord());
			end else if (roll < 9) begin
				px = nudge(cx, spread);
				py = nudge(cy, spread);
				send_item(ACT_LOAD, px, py);
				lx.push_back(px);
				ly.push_back(py);
			end else if (roll < 10) begin
				send_item(ACT_CLEAR, rand_coord(), rand_coord());
			end else if (roll < 20) begin
				send_item(ACT_MATCH, cx, cy);
			end else if (roll < 28 || lx.size() == 0) begin
				send_item(ACT_MATCH, rand_coord(), rand_coord());
			end else begin
				k = $urandom_range(0, lx.size() - 1);
				if ($urandom_range(0, 9) < 4)
					send_item(ACT_MATCH, lx[k], ly[k]);
				else
					send_item(ACT_MATCH, nudge(lx[k], jitter), nudge(ly[k], jitter));
			end
		end
	endtask

	task automatic compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin : result_sink
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = pick_gap(sink_calm);
			if (hold_armed) begin
				hold_armed = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.ref_index = m_axis_tdata[7:0];
			got.ref_x = m_axis_tdata[31:8];
			got.ref_y = m_axis_tdata[55:32];
			got.pair_index = m_axis_tdata[63:56];
			if (owed_results.size() == 0) begin
				$display("%0t: result transaction with none expected, got %0h status %0h",
					$time, m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				compare_field("status", want.status, got.status);
				compare_field("ref_index", want.ref_index, got.ref_index);
				compare_field("ref_x", want.ref_x, got.ref_x);
				compare_field("ref_y", want.ref_y, got.ref_y);
				compare_field("pair_index", want.pair_index, got.pair_index);
			end
		end
	end

	initial begin : stimulus
		res_t fixed;
		int k;
		int roll;
		int loads;
		logic [RADIUS_W-1:0] value;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_CLEAR;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		items_sent = 0;
		feed_calm = 0;
		sink_calm = 0;
		hold_armed = 1'b0;
		star_count = 0;
		pair_count = 0;
		radius_q = RADIUS_RESET;
		for (k = 0; k < MAX_REF; k++)
			star_used[k] = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			send_item(directed_rows[k].act, directed_rows[k].x, directed_rows[k].y);
			if (directed_rows[k].typed) begin
				fixed.status = directed_rows[k].st;
				fixed.ref_index = directed_rows[k].idx;
				fixed.ref_x = directed_rows[k].rx;
				fixed.ref_y = directed_rows[k].ry;
				fixed.pair_index = directed_rows[k].pr;
				owed_results[owed_results.size() - 1] = fixed;
			end
		end

		// radius extremes: exact hits only, then the widest circle
		write_radius('0);
		run_scene(1'b1, 8, 16);
		write_radius('1);
		run_scene(1'b1, 12, 20);

		// fill the store past full while the result side holds off
		write_radius(16'($urandom_range(256, 4096)));
		hold_armed = 1'b1;
		run_scene(1'b1, MAX_REF + 4, 30);

		while (items_sent < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					value = '0;
				else if (roll == 1)
					value = '1;
				else if (roll < 5)
					value = 16'($urandom_range(1, 1024));
				else
					value = 16'($urandom);
				write_radius(value);
			end
			roll = $urandom_range(0, 99);
			loads = (roll < 15) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			run_scene($urandom_range(0, 9) != 0, loads, loads + $urandom_range(0, 6));
		end

		drain(300);
		if (mismatches == 0)
			$display("greedy_nearest_star_matcher regression: pass");
		else
			$display("greedy_nearest_star_matcher regression: fail");
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("greedy_nearest_star_matcher regression: fail");
		$finish;
	end

endmodule
